// ----- sv/bta_pkg.sv -----
// Shared constants, types and state encoding for the buddy tree allocator.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package bta_pkg;

  // Tree size and field widths.
  localparam int LEVELS     = 10;
  localparam int CMD_W      = 1;
  localparam int LVL_W      = 4;
  localparam int NODE_W     = 10;
  localparam int ADDR_W     = LEVELS;
  localparam int NODE_COUNT = 1 << LEVELS;

  // Busy bits are kept in rows of one word each.
  localparam int BIT_W  = 5;
  localparam int WORD_W = 1 << BIT_W;
  localparam int ROW_W  = ADDR_W - BIT_W;
  localparam int ROWS   = 1 << ROW_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [BIT_W-1:0]  bitpos_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // One access to the busy bitmap: a read or a write of a whole row.
  typedef struct packed {
    logic  rd_en;
    row_t  rd_row;
    logic  wr_en;
    row_t  wr_row;
    word_t wr_data;
  } mem_req_t;

  // Request to the range unit: node base shifted down by sh levels, seen at one row.
  typedef struct packed {
    addr_t base;
    lvl_t  sh;
    row_t  row;
  } range_req_t;

  // Answer of the range unit: row span of the node range and the bit mask of one row.
  typedef struct packed {
    row_t  row_first;
    row_t  row_last;
    word_t mask;
  } range_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ANC_RD,
    S_ANC_WR,
    S_FILL_INIT,
    S_FILL_RD,
    S_FILL_WR,
    S_UP_CHK,
    S_UP_RD,
    S_UP_TST,
    S_UP_CLR_RD,
    S_UP_CLR_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/bta_req_if.sv -----
// Request channel of the buddy tree allocator: valid, ready and the command payload.
// Depends on bta_pkg for the field widths.
`default_nettype none

interface bta_req_if;
  logic                       valid;
  logic                       ready;
  logic [bta_pkg::CMD_W-1:0]  command;
  logic [bta_pkg::LVL_W-1:0]  alloc_level;
  logic [bta_pkg::NODE_W-1:0] release_node;

  modport source (output valid, command, alloc_level, release_node, input ready);
  modport sink   (input valid, command, alloc_level, release_node, output ready);
endinterface

`default_nettype wire

// ----- sv/bta_rsp_if.sv -----
// Response channel of the buddy tree allocator: valid, ready and the result payload.
// Depends on bta_pkg for the field widths.
`default_nettype none

interface bta_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bta_pkg::NODE_W-1:0] node;
  logic                       ok;

  modport source (output valid, node, ok, input ready);
  modport sink   (input valid, node, ok, output ready);
endinterface

`default_nettype wire

// ----- sv/buddy_tree_allocator.sv -----
// Buddy tree allocator: 1024-node busy tree kept as 32 rows of 32 bits. It handles one
// request at a time; every step reads one bitmap row and, where it marks or clears
// bits, writes it back, through the single read port of the bitmap and one shared
// range/mask unit. An allocate scans the rows at its level (up to 16 rows at the
// deepest level), marks each ancestor and then fills its subtree level by level. A
// release fills its subtree the same way and then walks upward. A new request is
// taken while the previous result still waits in the output register. No clearing
// pass is needed.
// Depends on bta_pkg, bta_req_if, bta_rsp_if, bta_range, bta_bitmap and bta_ctrl.
`default_nettype none

module buddy_tree_allocator (
  input  logic       clk,
  input  logic       rst,
  bta_req_if.sink    req,
  bta_rsp_if.source  rsp
);

  bta_pkg::mem_req_t   mreq;
  bta_pkg::word_t      rdata;
  bta_pkg::range_req_t rreq;
  bta_pkg::range_t     rng;

  // Sequencer.
  bta_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .mreq  (mreq),
    .rdata (rdata),
    .rreq  (rreq),
    .rng   (rng)
  );

  // Shared range and mask unit.
  bta_range u_range (
    .req (rreq),
    .rng (rng)
  );

  // Busy bitmap storage.
  bta_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- sv/bta_range.sv -----
// Range unit: turns a node and a level offset into a row span and a per-row bit mask.
// Shared by the scan, ancestor, subtree and buddy steps. Depends on bta_pkg.
`default_nettype none

module bta_range (
  input  bta_pkg::range_req_t req,
  output bta_pkg::range_t     rng
);

  bta_pkg::addr_t   first;
  bta_pkg::addr_t   last;
  bta_pkg::bitpos_t b0;
  bta_pkg::bitpos_t b1;

  // Node range at the target level: base << sh up to base << sh with all low bits set.
  always_comb begin
    first = req.base << req.sh;
    last  = first | ~(~bta_pkg::addr_t'(0) << req.sh);
  end

  // Mask of the bits of the range that fall in the selected row.
  always_comb begin
    rng.row_first = first[bta_pkg::ADDR_W-1:bta_pkg::BIT_W];
    rng.row_last  = last[bta_pkg::ADDR_W-1:bta_pkg::BIT_W];
    b0 = (req.row == rng.row_first) ? first[bta_pkg::BIT_W-1:0] : '0;
    b1 = (req.row == rng.row_last) ? last[bta_pkg::BIT_W-1:0] : '1;
    rng.mask = (~bta_pkg::word_t'(0) << b0) & (~bta_pkg::word_t'(0) >> (~b1));
  end

endmodule

`default_nettype wire

// ----- sv/bta_bitmap.sv -----
// Busy bitmap: one word per row, one registered read port and one write port.
// A row never written since reset reads as all free. Depends on bta_pkg.
`default_nettype none

module bta_bitmap (
  input  logic                clk,
  input  logic                rst,
  input  bta_pkg::mem_req_t   mreq,
  output bta_pkg::word_t      rdata
);

  bta_pkg::word_t            mem [bta_pkg::ROWS];
  logic [bta_pkg::ROWS-1:0]  row_valid;
  bta_pkg::word_t            rd_word;
  logic                      rd_valid;

  // Storage array: write and registered read.
  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_row] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_word <= mem[mreq.rd_row];
    end
  end

  // Row valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (mreq.wr_en) begin
        row_valid[mreq.wr_row] <= 1'b1;
      end
      if (mreq.rd_en) begin
        rd_valid <= row_valid[mreq.rd_row];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

// ----- sv/bta_ctrl.sv -----
// Sequencer of the buddy tree allocator: scan, ancestor marking, subtree fill and
// the upward release walk, all as read-modify-write steps on the bitmap.
// Depends on bta_pkg, bta_req_if and bta_rsp_if.
`default_nettype none

module bta_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  bta_req_if.sink              req,
  bta_rsp_if.source            rsp,
  output bta_pkg::mem_req_t    mreq,
  input  bta_pkg::word_t       rdata,
  output bta_pkg::range_req_t  rreq,
  input  bta_pkg::range_t      rng
);

  // Level of a node: index of its highest set bit.
  function automatic bta_pkg::lvl_t level_of(input bta_pkg::addr_t n);
    bta_pkg::lvl_t lv;
    lv = '0;
    for (int i = 0; i < bta_pkg::ADDR_W; i++) begin
      if (n[i]) lv = bta_pkg::lvl_t'(i);
    end
    return lv;
  endfunction

  // Position of the lowest set bit of a word.
  function automatic bta_pkg::bitpos_t lowest_one(input bta_pkg::word_t w);
    bta_pkg::bitpos_t pos;
    pos = '0;
    for (int i = bta_pkg::WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = bta_pkg::bitpos_t'(i);
    end
    return pos;
  endfunction

  bta_pkg::state_t state;
  bta_pkg::state_t state_next;

  logic           is_rel;
  bta_pkg::lvl_t  lvl;
  bta_pkg::addr_t node;
  bta_pkg::addr_t cur;
  bta_pkg::lvl_t  dsh;
  bta_pkg::row_t  r;
  bta_pkg::addr_t res_node;
  logic           res_ok;
  logic           out_valid;
  bta_pkg::addr_t out_node;
  logic           out_ok;

  logic           accept;
  logic           single;
  logic           rel_cmd;
  logic           rel_ok;
  logic           lvl_bad;
  bta_pkg::addr_t rel_addr;
  bta_pkg::word_t free_bits;
  logic           found_any;
  bta_pkg::addr_t found_node;
  logic           last_row;
  logic           last_level;
  logic           buddy_busy;
  logic           out_free;

  // Request decode and bitmap tests.
  always_comb begin
    accept     = req.valid && req.ready;
    rel_cmd    = (bta_pkg::cmd_t'(req.command) == bta_pkg::CMD_RELEASE);
    rel_addr   = bta_pkg::addr_t'(req.release_node);
    rel_ok     = (req.release_node != '0) &&
                 (req.release_node <= bta_pkg::NODE_W'(bta_pkg::NODE_COUNT - 1));
    lvl_bad    = (req.alloc_level > bta_pkg::lvl_t'(bta_pkg::LEVELS - 1));
    free_bits  = ~rdata & rng.mask;
    found_any  = |free_bits;
    found_node = {r, lowest_one(free_bits)};
    last_row   = (r == rng.row_last);
    last_level = (bta_pkg::lvl_t'(lvl + dsh) == bta_pkg::lvl_t'(bta_pkg::LEVELS - 1));
    buddy_busy = |(rdata & rng.mask);
    out_free   = !out_valid || rsp.ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bta_pkg::S_IDLE: begin
        if (accept) begin
          if (rel_cmd) begin
            state_next = rel_ok ? bta_pkg::S_FILL_INIT : bta_pkg::S_DONE;
          end else begin
            state_next = lvl_bad ? bta_pkg::S_DONE : bta_pkg::S_SCAN_INIT;
          end
        end
      end
      bta_pkg::S_SCAN_INIT: state_next = bta_pkg::S_SCAN_RD;
      bta_pkg::S_SCAN_RD:   state_next = bta_pkg::S_SCAN_CHK;
      bta_pkg::S_SCAN_CHK: begin
        if (found_any) begin
          state_next = (lvl != '0) ? bta_pkg::S_ANC_RD : bta_pkg::S_FILL_INIT;
        end else begin
          state_next = last_row ? bta_pkg::S_DONE : bta_pkg::S_SCAN_RD;
        end
      end
      bta_pkg::S_ANC_RD: state_next = bta_pkg::S_ANC_WR;
      bta_pkg::S_ANC_WR: begin
        state_next = ((cur >> 1) == '0) ? bta_pkg::S_FILL_INIT : bta_pkg::S_ANC_RD;
      end
      bta_pkg::S_FILL_INIT: state_next = bta_pkg::S_FILL_RD;
      bta_pkg::S_FILL_RD:   state_next = bta_pkg::S_FILL_WR;
      bta_pkg::S_FILL_WR: begin
        priority if (!last_row) begin
          state_next = bta_pkg::S_FILL_RD;
        end else if (!last_level) begin
          state_next = bta_pkg::S_FILL_INIT;
        end else begin
          state_next = is_rel ? bta_pkg::S_UP_CHK : bta_pkg::S_DONE;
        end
      end
      bta_pkg::S_UP_CHK: begin
        state_next = (cur <= bta_pkg::addr_t'(1)) ? bta_pkg::S_DONE : bta_pkg::S_UP_RD;
      end
      bta_pkg::S_UP_RD: state_next = bta_pkg::S_UP_TST;
      bta_pkg::S_UP_TST: begin
        state_next = buddy_busy ? bta_pkg::S_DONE : bta_pkg::S_UP_CLR_RD;
      end
      bta_pkg::S_UP_CLR_RD: state_next = bta_pkg::S_UP_CLR_WR;
      bta_pkg::S_UP_CLR_WR: state_next = bta_pkg::S_UP_CHK;
      bta_pkg::S_DONE: begin
        if (out_free) state_next = bta_pkg::S_IDLE;
      end
      default: state_next = bta_pkg::S_IDLE;
    endcase
  end

  // Outputs: range unit operand, bitmap access and handshake.
  always_comb begin
    req.ready    = (state == bta_pkg::S_IDLE);
    rreq.base    = node;
    rreq.sh      = '0;
    single       = 1'b1;
    mreq.rd_en   = 1'b0;
    mreq.wr_en   = 1'b0;
    mreq.wr_data = rdata;
    unique case (state)
      bta_pkg::S_SCAN_INIT, bta_pkg::S_SCAN_RD, bta_pkg::S_SCAN_CHK: begin
        rreq.base  = bta_pkg::addr_t'(1);
        rreq.sh    = lvl;
        single     = 1'b0;
        mreq.rd_en = (state == bta_pkg::S_SCAN_RD);
      end
      bta_pkg::S_ANC_RD, bta_pkg::S_ANC_WR: begin
        rreq.base    = cur;
        mreq.rd_en   = (state == bta_pkg::S_ANC_RD);
        mreq.wr_en   = (state == bta_pkg::S_ANC_WR);
        mreq.wr_data = rdata | rng.mask;
      end
      bta_pkg::S_FILL_INIT, bta_pkg::S_FILL_RD, bta_pkg::S_FILL_WR: begin
        rreq.base    = node;
        rreq.sh      = dsh;
        single       = 1'b0;
        mreq.rd_en   = (state == bta_pkg::S_FILL_RD);
        mreq.wr_en   = (state == bta_pkg::S_FILL_WR);
        mreq.wr_data = is_rel ? (rdata & ~rng.mask) : (rdata | rng.mask);
      end
      bta_pkg::S_UP_RD, bta_pkg::S_UP_TST: begin
        rreq.base  = cur ^ bta_pkg::addr_t'(1);
        mreq.rd_en = (state == bta_pkg::S_UP_RD);
      end
      bta_pkg::S_UP_CLR_RD, bta_pkg::S_UP_CLR_WR: begin
        rreq.base    = cur;
        mreq.rd_en   = (state == bta_pkg::S_UP_CLR_RD);
        mreq.wr_en   = (state == bta_pkg::S_UP_CLR_WR);
        mreq.wr_data = rdata & ~rng.mask;
      end
      default: begin
        rreq.base = node;
      end
    endcase
    // A single node sits in the row given by the upper bits of its number.
    rreq.row    = single ? rreq.base[bta_pkg::ADDR_W-1:bta_pkg::BIT_W] : r;
    mreq.rd_row = rreq.row;
    mreq.wr_row = rreq.row;
  end

  assign rsp.valid = out_valid;
  assign rsp.node  = bta_pkg::NODE_W'(out_node);
  assign rsp.ok    = out_ok;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bta_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bta_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    unique case (state)
      bta_pkg::S_IDLE: begin
        if (accept) begin
          is_rel   <= rel_cmd;
          lvl      <= rel_cmd ? level_of(rel_addr) : req.alloc_level;
          node     <= rel_addr;
          cur      <= rel_addr;
          dsh      <= '0;
          res_node <= (rel_cmd && rel_ok) ? rel_addr : '0;
          res_ok   <= rel_cmd && rel_ok;
        end
      end
      bta_pkg::S_SCAN_INIT, bta_pkg::S_FILL_INIT: begin
        r <= rng.row_first;
      end
      bta_pkg::S_SCAN_CHK: begin
        if (found_any) begin
          node     <= found_node;
          cur      <= found_node >> 1;
          res_node <= found_node;
          res_ok   <= 1'b1;
        end else begin
          r <= r + bta_pkg::row_t'(1);
        end
      end
      bta_pkg::S_ANC_WR: begin
        cur <= cur >> 1;
      end
      bta_pkg::S_FILL_WR: begin
        if (!last_row) begin
          r <= r + bta_pkg::row_t'(1);
        end else begin
          dsh <= dsh + bta_pkg::lvl_t'(1);
        end
      end
      bta_pkg::S_UP_TST: begin
        if (!buddy_busy) cur <= cur >> 1;
      end
      bta_pkg::S_DONE: begin
        if (out_free) begin
          out_node <= res_node;
          out_ok   <= res_ok;
        end
      end
      default: begin
      end
    endcase
  end

  // A bitmap write always completes a read of the cycle before.
  ap_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    mreq.wr_en |-> $past(mreq.rd_en))
    else $error("bitmap write without a preceding read");

  // A failed request reports node zero.
  ap_fail_node: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |-> (rsp.node == '0))
    else $error("failed request reports a nonzero node");

  // A successful request reports a real node.
  ap_ok_node: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ok) |-> (rsp.node != '0))
    else $error("successful request reports node zero");

  // An accepted request always leaves the idle state.
  ap_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != bta_pkg::S_IDLE))
    else $error("request transfer left the sequencer idle");

endmodule

`default_nettype wire
